[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// Each macro writes one clocked, reset-qualified concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent are checked in the same cycle.
`define CNIG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define CNIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cnig_pkg.sv]
// ---------------------------------------------------------------------------
// cnig_pkg
// Shared constants, types and the neighbour slot table of the generator.
// ---------------------------------------------------------------------------
package cnig_pkg;

  localparam int unsigned IndexWidth       = 16;
  localparam int unsigned DivStepsPerCycle = 2;
  localparam int unsigned DivIters         = IndexWidth / DivStepsPerCycle;

  localparam int unsigned GridWidthBits = 9;
  localparam logic [GridWidthBits-1:0] GridWidthReset = 9'd16;

  localparam int unsigned RegIndexWidth = 2;
  localparam logic [RegIndexWidth-1:0] RegGridWidth    = 2'd0;
  localparam logic [RegIndexWidth-1:0] RegBoundaryMode = 2'd1;

  localparam int unsigned NumSlots  = 9;
  localparam int unsigned SlotWidth = $clog2(NumSlots);

  // Selects for the column (left, same, right) and row (below, same, above).
  localparam logic [1:0] SelLow  = 2'd0;
  localparam logic [1:0] SelMid  = 2'd1;
  localparam logic [1:0] SelHigh = 2'd2;

  typedef struct packed {
    logic [1:0] col_sel;
    logic [1:0] row_sel;
  } slot_t;

  // Maps a slot of the emission list to the column and row it refers to.
  function automatic slot_t slot_map(input logic open_mode, input logic one_d,
                                     input logic [SlotWidth-1:0] slot);
    slot_t s;
    s.col_sel = SelMid;
    s.row_sel = SelMid;
    if (one_d) begin
      unique case (slot)
        4'd1:    s.col_sel = SelLow;
        4'd2:    s.col_sel = SelHigh;
        default: s.col_sel = SelMid;
      endcase
    end else if (open_mode) begin
      unique case (slot)
        4'd1:    s = '{SelLow,  SelMid};
        4'd2:    s = '{SelLow,  SelLow};
        4'd3:    s = '{SelLow,  SelHigh};
        4'd4:    s = '{SelMid,  SelLow};
        4'd5:    s = '{SelMid,  SelHigh};
        4'd6:    s = '{SelHigh, SelMid};
        4'd7:    s = '{SelHigh, SelLow};
        4'd8:    s = '{SelHigh, SelHigh};
        default: s = '{SelMid,  SelMid};
      endcase
    end else begin
      unique case (slot)
        4'd1:    s = '{SelLow,  SelLow};
        4'd2:    s = '{SelLow,  SelMid};
        4'd3:    s = '{SelLow,  SelHigh};
        4'd4:    s = '{SelMid,  SelLow};
        4'd5:    s = '{SelMid,  SelHigh};
        4'd6:    s = '{SelHigh, SelLow};
        4'd7:    s = '{SelHigh, SelMid};
        4'd8:    s = '{SelHigh, SelHigh};
        default: s = '{SelMid,  SelMid};
      endcase
    end
    return s;
  endfunction

endpackage

[design/cnig_fifo.sv]
// ---------------------------------------------------------------------------
// cnig_fifo
// Small register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module cnig_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/cnig_front.sv]
// ---------------------------------------------------------------------------
// cnig_front
// Accepts cell indices and splits them into column and row by division.
// ---------------------------------------------------------------------------
module cnig_front #(
  parameter int unsigned W_WIDTH    = 9,
  parameter int unsigned DIMENSIONS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [cnig_pkg::IndexWidth-1:0]  cell_index_i,
  input  logic [W_WIDTH-1:0]               grid_width_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output logic [cnig_pkg::IndexWidth-1:0]  push_id_o,
  output logic [W_WIDTH-1:0]               push_col_o,
  output logic [W_WIDTH-1:0]               push_row_o,
  output logic                             push_err_o
);

  import cnig_pkg::*;

  localparam int unsigned CntW = (DivIters > 1) ? $clog2(DivIters) : 1;

  localparam logic [1:0] FrIdle = 2'd0;
  localparam logic [1:0] FrDiv  = 2'd1;
  localparam logic [1:0] FrPush = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IndexWidth-1:0] id_q, dvd_q, dvd_n, quot;
  logic [W_WIDTH-1:0]    rem_q, rem_n;
  logic [W_WIDTH:0]      trial;
  logic                  last_iter;

  // Restoring division, a fixed number of quotient bits per cycle.
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int s = 0; s < DivStepsPerCycle; s++) begin
      trial = {rem_n, dvd_n[IndexWidth-1]};
      if (trial >= {1'b0, grid_width_i}) begin
        rem_n = W_WIDTH'(trial - {1'b0, grid_width_i});
        dvd_n = {dvd_n[IndexWidth-2:0], 1'b1};
      end else begin
        rem_n = trial[W_WIDTH-1:0];
        dvd_n = {dvd_n[IndexWidth-2:0], 1'b0};
      end
    end
  end

  assign last_iter = cnt_q == CntW'(DivIters - 1);
  assign busy_o    = state_q != FrIdle;

  // The last division cycle offers its result straight to the queue.
  assign quot       = (state_q == FrDiv) ? dvd_n : dvd_q;
  assign push_col_o = (state_q == FrDiv) ? rem_n : rem_q;
  assign push_row_o = quot[W_WIDTH-1:0];
  assign push_id_o  = id_q;
  assign push_err_o = (DIMENSIONS == 1) ? (quot != '0)
                                        : (quot >= IndexWidth'(grid_width_i));
  assign push_valid_o = ((state_q == FrDiv) && last_iter) || (state_q == FrPush);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      FrIdle: begin
        if (start_i) begin
          state_d = FrDiv;
          cnt_d   = '0;
        end
      end
      FrDiv: begin
        cnt_d = cnt_q + CntW'(1);
        if (last_iter) begin
          state_d = push_ready_i ? FrIdle : FrPush;
        end
      end
      FrPush: begin
        if (push_ready_i) begin
          state_d = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == FrIdle) && start_i) begin
      id_q  <= cell_index_i;
      dvd_q <= cell_index_i;
      rem_q <= '0;
    end else if (state_q == FrDiv) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
  end

endmodule

[design/cnig_back.sv]
// ---------------------------------------------------------------------------
// cnig_back
// Builds the neighbour list of one cell and sends it out one entry a cycle.
// ---------------------------------------------------------------------------
module cnig_back #(
  parameter int unsigned W_WIDTH    = 9,
  parameter int unsigned DIMENSIONS = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [W_WIDTH-1:0]               grid_width_i,
  input  logic                             open_mode_i,
  input  logic                             pop_valid_i,
  output logic                             pop_ready_o,
  input  logic [cnig_pkg::IndexWidth-1:0]  pop_id_i,
  input  logic [W_WIDTH-1:0]               pop_col_i,
  input  logic [W_WIDTH-1:0]               pop_row_i,
  input  logic                             pop_err_i,
  output logic                             result_strobe_o,
  output logic [cnig_pkg::IndexWidth-1:0]  neighbour_index_o,
  output logic                             last_entry_o,
  output logic                             index_error_o
);

  import cnig_pkg::*;

  localparam bit OneD = (DIMENSIONS == 1);

  logic [IndexWidth-1:0] w16, wsq_q, col16;
  logic [2*W_WIDTH-1:0]  wsq_full;
  logic [W_WIDTH-1:0]    w_m1;

  logic                  act_q, act_d;
  logic [NumSlots-1:0]   mask_q, mask_d, load_mask, onehot, rest;
  logic                  err_q, open_q;
  logic [IndexWidth-1:0] rb_lo_q, rb_mid_q, rb_hi_q;
  logic [W_WIDTH-1:0]    cv_lo_q, cv_mid_q, cv_hi_q;
  logic                  hl, hr, hb, ht, per, load;
  logic [SlotWidth-1:0]  sel;
  slot_t                 slot;
  logic [IndexWidth-1:0] row_base;
  logic [W_WIDTH-1:0]    col_val;

  logic                  strobe_q, last_q, ierr_q;
  logic [IndexWidth-1:0] idx_q;

  assign wsq_full = grid_width_i * grid_width_i;
  assign w16      = IndexWidth'(grid_width_i);
  assign w_m1     = grid_width_i - W_WIDTH'(1);
  assign col16    = IndexWidth'(pop_col_i);

  // Width squared only changes with configuration, so one register suffices.
  always_ff @(posedge clk_i) begin
    wsq_q <= IndexWidth'(wsq_full);
  end

  // Edge flags and the set of slots that this cell's list contains.
  assign hl  = pop_col_i != '0;
  assign hr  = pop_col_i != w_m1;
  assign hb  = pop_row_i != '0;
  assign ht  = pop_row_i != w_m1;
  assign per = !open_mode_i;

  always_comb begin
    load_mask = '0;
    if (pop_err_i) begin
      load_mask[0] = 1'b1;
    end else if (OneD) begin
      load_mask[0] = 1'b1;
      load_mask[1] = per || hl;
      load_mask[2] = per || hr;
    end else if (per) begin
      load_mask = '1;
    end else begin
      load_mask = {hr && ht, hr && hb, hr, ht, hb, hl && ht, hl && hb, hl, 1'b1};
    end
  end

  // Lowest pending slot goes out next.
  always_comb begin
    sel = '0;
    for (int k = NumSlots - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel = SlotWidth'(k);
      end
    end
  end

  assign onehot      = NumSlots'(1) << sel;
  assign rest        = mask_q & ~onehot;
  assign slot        = slot_map(open_q, OneD, sel);
  assign pop_ready_o = !act_q || (rest == '0);
  assign load        = pop_ready_o && pop_valid_i;

  always_comb begin
    case (slot.row_sel)
      SelLow:  row_base = rb_lo_q;
      SelHigh: row_base = rb_hi_q;
      default: row_base = rb_mid_q;
    endcase
    case (slot.col_sel)
      SelLow:  col_val = cv_lo_q;
      SelHigh: col_val = cv_hi_q;
      default: col_val = cv_mid_q;
    endcase
  end

  always_comb begin
    act_d  = act_q;
    mask_d = mask_q;
    if (load) begin
      act_d  = 1'b1;
      mask_d = load_mask;
    end else if (act_q) begin
      act_d  = rest != '0;
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      mask_q   <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      ierr_q   <= 1'b0;
    end else begin
      act_q    <= act_d;
      mask_q   <= mask_d;
      strobe_q <= act_q;
      last_q   <= act_q && (rest == '0);
      ierr_q   <= act_q && err_q;
    end
  end

  // Row starts and column offsets; wrapped values are used in periodic mode only.
  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q    <= pop_err_i;
      open_q   <= open_mode_i;
      rb_mid_q <= pop_id_i - col16;
      rb_lo_q  <= (pop_row_i == '0) ? (wsq_q - w16) : (pop_id_i - col16 - w16);
      rb_hi_q  <= (pop_row_i == w_m1) ? '0 : (pop_id_i - col16 + w16);
      cv_mid_q <= pop_col_i;
      cv_lo_q  <= (pop_col_i == '0) ? w_m1 : (pop_col_i - W_WIDTH'(1));
      cv_hi_q  <= (pop_col_i == w_m1) ? '0 : (pop_col_i + W_WIDTH'(1));
    end
    idx_q <= err_q ? '0 : (row_base + IndexWidth'(col_val));
  end

  assign result_strobe_o   = strobe_q;
  assign neighbour_index_o = idx_q;
  assign last_entry_o      = last_q;
  assign index_error_o     = ierr_q;

endmodule

[design/cell_neighbour_index_generator.sv]
// ---------------------------------------------------------------------------
// cell_neighbour_index_generator
// Lists a grid cell and its neighbour cells, periodic or open boundaries.
// ---------------------------------------------------------------------------
// Usage:
// A cell index is taken at a rising edge where start is high and busy is low.
// The front end then divides it by the grid width, two quotient bits per
// cycle, and keeps busy high until the result has entered the queue, so a
// new index can follow only once busy is low again. Column, row and an
// out-of-grid flag go into a two-entry queue. The back end pops one entry
// and sends one list entry per cycle on the result ports, each marked by
// result_strobe_o for one cycle; last_entry_o marks the final entry of a
// cell. A periodic 2D list has nine entries, an open list fewer at the grid
// edges, an out-of-grid index a single entry with index_error_o set. When
// the queue holds the next cell, its list follows the previous one without
// a gap. The receiver cannot stall: every strobe is a delivered result.
// Configuration writes (grid width, boundary mode) are always ready and must
// be made only while the block is idle. Reset clears the queue and all
// control state and loads a width of 16 with periodic boundaries.
// ---------------------------------------------------------------------------
module cell_neighbour_index_generator #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned DIMENSIONS = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cnig_pkg::IndexWidth-1:0]    cell_index_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cnig_pkg::RegIndexWidth-1:0] cfg_index_i,
  input  logic [cnig_pkg::GridWidthBits-1:0] cfg_data_i,
  output logic                               result_strobe_o,
  output logic [cnig_pkg::IndexWidth-1:0]    neighbour_index_o,
  output logic                               last_entry_o,
  output logic                               index_error_o
);

  import cnig_pkg::*;

  // The width register is 9 bits, so the usable width never exceeds 511.
  localparam int unsigned RegMax    = (1 << GridWidthBits) - 1;
  localparam int unsigned EffMax    = (MAX_WIDTH < RegMax) ? MAX_WIDTH : RegMax;
  localparam int unsigned WW        = $clog2(EffMax + 1);
  localparam int unsigned FifoWidth = IndexWidth + 2 * WW + 1;
  localparam int unsigned FifoDepth = 2;

  logic [GridWidthBits-1:0] grid_width_q;
  logic                     boundary_mode_q;
  logic [31:0]              w_sat;
  logic [WW-1:0]            w_eff;

  logic                  push_valid, push_ready, push_err;
  logic [IndexWidth-1:0] push_id;
  logic [WW-1:0]         push_col, push_row;
  logic                  pop_valid, pop_ready;
  logic [FifoWidth-1:0]  push_data, pop_data;

  // Configuration registers; writes to unknown indices are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= GridWidthReset;
      boundary_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegGridWidth:    grid_width_q    <= cfg_data_i;
        RegBoundaryMode: boundary_mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // A width of zero acts as one; widths beyond the build limit saturate.
  always_comb begin
    if (grid_width_q == '0) begin
      w_sat = 32'd1;
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end else begin
      w_sat = 32'(grid_width_q);
    end
  end

  assign w_eff = w_sat[WW-1:0];

  cnig_front #(
    .W_WIDTH    (WW),
    .DIMENSIONS (DIMENSIONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .cell_index_i (cell_index_i),
    .grid_width_i (w_eff),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_id_o    (push_id),
    .push_col_o   (push_col),
    .push_row_o   (push_row),
    .push_err_o   (push_err)
  );

  assign push_data = {push_id, push_col, push_row, push_err};

  cnig_fifo #(
    .WIDTH (FifoWidth),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cnig_back #(
    .W_WIDTH    (WW),
    .DIMENSIONS (DIMENSIONS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .grid_width_i      (w_eff),
    .open_mode_i       (boundary_mode_q),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_id_i          (pop_data[FifoWidth-1 -: IndexWidth]),
    .pop_col_i         (pop_data[2*WW -: WW]),
    .pop_row_i         (pop_data[WW -: WW]),
    .pop_err_i         (pop_data[0]),
    .result_strobe_o   (result_strobe_o),
    .neighbour_index_o (neighbour_index_o),
    .last_entry_o      (last_entry_o),
    .index_error_o     (index_error_o)
  );

endmodule

[design/cnig_checker.sv]
// ---------------------------------------------------------------------------
// cnig_checker
// Port-level checks of the neighbour index generator, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cnig_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic [cnig_pkg::IndexWidth-1:0]    cell_index_i,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [cnig_pkg::RegIndexWidth-1:0] cfg_index_i,
  input logic [cnig_pkg::GridWidthBits-1:0] cfg_data_i,
  input logic                               result_strobe_o,
  input logic [cnig_pkg::IndexWidth-1:0]    neighbour_index_o,
  input logic                               last_entry_o,
  input logic                               index_error_o
);

  // A start transaction keeps the front end busy in the next cycle.
  `CNIG_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy, "busy low after start")

  // Flags carry meaning only together with a result strobe.
  `CNIG_ASSERT_NOW(a_flags_need_strobe, clk_i, rst_ni, !result_strobe_o, !last_entry_o && !index_error_o, "flag without strobe")

  // An out-of-grid cell gives one entry with a zero index.
  `CNIG_ASSERT_NOW(a_error_single, clk_i, rst_ni, result_strobe_o && index_error_o, last_entry_o && (neighbour_index_o == '0), "bad error entry")

  // The entries of one cell leave in consecutive cycles.
  `CNIG_ASSERT_NEXT(a_list_contiguous, clk_i, rst_ni, result_strobe_o && !last_entry_o, result_strobe_o, "gap inside a list")

endmodule

bind cell_neighbour_index_generator cnig_checker u_cnig_checker (.*);

[sim/cell_neighbour_index_generator_test.sv]
// ---------------------------------------------------------------------------
// cell_neighbour_index_generator_test
// Self-checking bench for the cell neighbour index generator. A queue of
// pending operations (cell indices and register writes) feeds a clocked
// driver. A clocked monitor predicts the neighbour list of every accepted
// cell and checks each result strobe against the oldest open expectation.
// ---------------------------------------------------------------------------
module cell_neighbour_index_generator_test;
  import cnig_pkg::*;

  localparam int unsigned MaxWidth      = 256;
  localparam int unsigned Dims          = 2;
  localparam logic        BoundaryWrap  = 1'b0;
  localparam logic        BoundaryOpen  = 1'b1;
  // Index 3 maps to no register; a write there must leave the setup alone.
  localparam logic [RegIndexWidth-1:0] RegUnmapped = 2'd3;
  localparam int unsigned ResetCycles   = 10;
  // Idle cycles required after the last result before a register write.
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned ItemsPerPhase = 38;

  // One entry of the pending stimulus: either a cell transaction or a
  // register write, with the number of idle cycles to insert before it.
  typedef struct {
    bit                         is_cfg;
    logic [RegIndexWidth-1:0]   reg_idx;
    logic [GridWidthBits-1:0]   cfg_data;
    logic [IndexWidth-1:0]      cell_id;
    int unsigned                gap;
  } pending_op_t;

  typedef struct {
    logic [IndexWidth-1:0] neighbour;
    logic                  is_last;
    logic                  err_flag;
  } neighbour_entry_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [IndexWidth-1:0]    cell_index_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [RegIndexWidth-1:0] cfg_index_i = '0;
  logic [GridWidthBits-1:0] cfg_data_i = '0;
  logic                     result_strobe_o;
  logic [IndexWidth-1:0]    neighbour_index_o;
  logic                     last_entry_o;
  logic                     index_error_o;

  pending_op_t      pending_ops[$];
  neighbour_entry_t expected_entries[$];

  // Shadow copy of the block's registers, updated on each accepted write.
  logic [GridWidthBits-1:0] width_reg = GridWidthReset;
  logic                     mode_reg  = BoundaryWrap;

  // Handshake flags from the monitor to the driver, one per channel.
  logic        item_taken = 1'b0;
  logic        cfg_taken  = 1'b0;
  bit          driver_active = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  // Stimulus planning state: the effective width that will be in force when
  // the next queued cell is sent, and whether gaps are currently suppressed.
  int unsigned plan_w = GridWidthReset;
  bit          quiet = 1'b0;

  cell_neighbour_index_generator #(
    .MAX_WIDTH (MaxWidth),
    .DIMENSIONS(Dims)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cell_index_i     (cell_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_strobe_o  (result_strobe_o),
    .neighbour_index_o(neighbour_index_o),
    .last_entry_o     (last_entry_o),
    .index_error_o    (index_error_o)
  );

  always #4 clk_i = ~clk_i;

  // Computes the neighbour list of one accepted cell under the current
  // shadow registers and appends it to the expectation queue. The width is
  // first clamped: zero acts as one and anything above MaxWidth saturates.
  function automatic void predict_neighbours(input logic [IndexWidth-1:0] cell_id);
    int unsigned      w, col, row, lc, rc, br, tr, span;
    bit               has_l, has_r, has_b, has_t;
    logic [IndexWidth-1:0] hits[$];
    neighbour_entry_t entry;
    w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
    span = (Dims == 1) ? w : w * w;
    // A cell outside the grid yields exactly one flagged entry.
    if (cell_id >= span) begin
      entry.neighbour = '0;
      entry.is_last   = 1'b1;
      entry.err_flag  = 1'b1;
      expected_entries.push_back(entry);
      return;
    end
    if (Dims == 1) begin
      hits.push_back(cell_id);
      if (mode_reg == BoundaryWrap) begin
        hits.push_back(cell_id == 0 ? w - 1 : cell_id - 1);
        hits.push_back(cell_id == w - 1 ? 0 : cell_id + 1);
      end else begin
        if (cell_id > 0) hits.push_back(cell_id - 1);
        if (cell_id < w - 1) hits.push_back(cell_id + 1);
      end
    end else begin
      col = cell_id % w;
      row = cell_id / w;
      hits.push_back(row * w + col);
      if (mode_reg == BoundaryWrap) begin
        // Wrapped coordinates; on tiny grids these repeat the cell itself.
        lc = (col == 0) ? w - 1 : col - 1;
        rc = (col == w - 1) ? 0 : col + 1;
        br = (row == 0) ? w - 1 : row - 1;
        tr = (row == w - 1) ? 0 : row + 1;
        hits.push_back(br * w + lc);
        hits.push_back(row * w + lc);
        hits.push_back(tr * w + lc);
        hits.push_back(br * w + col);
        hits.push_back(tr * w + col);
        hits.push_back(br * w + rc);
        hits.push_back(row * w + rc);
        hits.push_back(tr * w + rc);
      end else begin
        // Open edges: the left column comes with the same row first.
        has_l = (col != 0);
        has_r = (col != w - 1);
        has_b = (row != 0);
        has_t = (row != w - 1);
        if (has_l) begin
          hits.push_back(row * w + col - 1);
          if (has_b) hits.push_back((row - 1) * w + col - 1);
          if (has_t) hits.push_back((row + 1) * w + col - 1);
        end
        if (has_b) hits.push_back((row - 1) * w + col);
        if (has_t) hits.push_back((row + 1) * w + col);
        if (has_r) begin
          hits.push_back(row * w + col + 1);
          if (has_b) hits.push_back((row - 1) * w + col + 1);
          if (has_t) hits.push_back((row + 1) * w + col + 1);
        end
      end
    end
    foreach (hits[k]) begin
      entry.neighbour = hits[k];
      entry.is_last   = (k == hits.size() - 1);
      entry.err_flag  = 1'b0;
      expected_entries.push_back(entry);
    end
  endfunction

  // Queues a register write and tracks the width that results from it.
  task automatic add_write(input logic [RegIndexWidth-1:0] idx,
                           input logic [GridWidthBits-1:0] data);
    pending_op_t op;
    op.is_cfg   = 1'b1;
    op.reg_idx  = idx;
    op.cfg_data = data;
    op.cell_id  = '0;
    op.gap      = $urandom_range(0, 6);
    pending_ops.push_back(op);
    if (idx == RegGridWidth) begin
      plan_w = (data == 0) ? 1 : (data > MaxWidth) ? MaxWidth : data;
    end
  endtask

  // Queues a cell transaction. Now and then the bench switches between
  // random gaps and back-to-back stretches so both kinds of traffic occur.
  task automatic add_cell(input logic [IndexWidth-1:0] cell_id);
    pending_op_t op;
    if ($urandom_range(0, 29) == 0) quiet = ~quiet;
    op.is_cfg   = 1'b0;
    op.reg_idx  = '0;
    op.cfg_data = '0;
    op.cell_id  = cell_id;
    op.gap      = quiet ? 0 : $urandom_range(0, 6);
    pending_ops.push_back(op);
  endtask

  // Picks a coordinate on the low edge, the high edge or anywhere between.
  function automatic int unsigned edge_coord(input int unsigned w);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return w - 1;
      default: return $urandom_range(0, w - 1);
    endcase
  endfunction

  // Driver: changes the inputs at the falling edge only. A transaction ends
  // when the monitor reports it as taken at the previous rising edge; the
  // next operation may then follow in the same step, so start or valid is
  // computed once and assigned once per step.
  always @(negedge clk_i) begin
    logic        nxt_start, nxt_cfg_valid;
    pending_op_t op;
    static bit          gap_loaded = 1'b0;
    static int unsigned hold = 0;
    if (rst_ni) begin
      nxt_start     = start;
      nxt_cfg_valid = cfg_valid_i;
      if (start && item_taken) begin
        nxt_start     = 1'b0;
        driver_active = 1'b0;
      end
      if (cfg_valid_i && cfg_taken) begin
        nxt_cfg_valid = 1'b0;
        driver_active = 1'b0;
      end
      if (!driver_active && pending_ops.size() > 0) begin
        if (!gap_loaded) begin
          hold       = pending_ops[0].gap;
          gap_loaded = 1'b1;
        end
        if (hold > 0) begin
          hold--;
        end else if (!pending_ops[0].is_cfg ||
                     (expected_entries.size() == 0 && idle_cycles >= SettleCycles)) begin
          // Register writes wait until the block has drained completely.
          op            = pending_ops.pop_front();
          gap_loaded    = 1'b0;
          driver_active = 1'b1;
          if (op.is_cfg) begin
            nxt_cfg_valid = 1'b1;
            cfg_index_i  <= op.reg_idx;
            cfg_data_i   <= op.cfg_data;
          end else begin
            nxt_start     = 1'b1;
            cell_index_i <= op.cell_id;
          end
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // Monitor: samples everything at the rising edge. It checks result
  // strobes first, then records accepted transactions on both channels.
  always @(posedge clk_i) begin
    neighbour_entry_t exp_entry;
    if (rst_ni) begin
      if (result_strobe_o) begin
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected result, neighbour_index %0d last %0b error %0b",
                   $time, neighbour_index_o, last_entry_o, index_error_o);
          failures++;
        end else begin
          exp_entry = expected_entries.pop_front();
          if (neighbour_index_o !== exp_entry.neighbour) begin
            $display("%0t: neighbour_index mismatch, expected %0d, actual %0d",
                     $time, exp_entry.neighbour, neighbour_index_o);
            failures++;
          end
          if (last_entry_o !== exp_entry.is_last) begin
            $display("%0t: last_entry mismatch, expected %0b, actual %0b",
                     $time, exp_entry.is_last, last_entry_o);
            failures++;
          end
          if (index_error_o !== exp_entry.err_flag) begin
            $display("%0t: index_error mismatch, expected %0b, actual %0b",
                     $time, exp_entry.err_flag, index_error_o);
            failures++;
          end
        end
      end
      if (start && !busy) predict_neighbours(cell_index_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegGridWidth:    width_reg = cfg_data_i;
          RegBoundaryMode: mode_reg  = cfg_data_i[0];
          default:         ;
        endcase
      end
      item_taken <= start && !busy;
      cfg_taken  <= cfg_valid_i && cfg_ready_o;
      if (expected_entries.size() == 0 && !busy && !start) idle_cycles++;
      else idle_cycles = 0;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sel, span, col, row, extra;
    logic [IndexWidth-1:0] cell_val;

    // Directed part, first under the reset setup: width 16, wrapping.
    add_cell(0);
    add_cell(255);
    add_cell(17);
    add_cell(15);
    add_cell(240);
    add_cell(256);
    add_cell(16'hFFFF);
    // A one-cell grid: every wrapped neighbour is the cell itself.
    add_write(RegGridWidth, 1);
    add_cell(0);
    add_cell(1);
    // The same grid with open edges lists only the cell.
    add_write(RegBoundaryMode, BoundaryOpen);
    add_cell(0);
    add_write(RegGridWidth, 2);
    add_cell(3);
    add_write(RegGridWidth, 3);
    add_cell(4);
    add_cell(0);
    add_cell(8);
    // A width of zero acts as one.
    add_write(RegGridWidth, 0);
    add_write(RegBoundaryMode, BoundaryWrap);
    add_cell(0);
    // All ones saturates to the largest width, which covers every index.
    add_write(RegGridWidth, 9'h1FF);
    add_cell(16'hFFFF);
    add_cell(0);
    add_cell(16'h8000);
    // Only bit zero of the boundary write counts.
    add_write(RegBoundaryMode, 9'h1FF);
    add_write(RegGridWidth, MaxWidth);
    add_cell(16'hFFFF);
    add_cell(257);
    add_write(RegGridWidth, MaxWidth + 1);
    add_write(RegBoundaryMode, 9'h1FE);
    add_write(RegUnmapped, 9'h1FF);
    add_cell(300);
    add_write(RegGridWidth, 2);
    add_cell(0);
    add_cell(3);
    add_cell(4);

    // Random part: each phase picks a new setup, mostly small grids so the
    // edges and the wrap-around are hit often, then sends a batch of cells.
    for (int p = 0; p < RandomPhases; p++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6)      add_write(RegGridWidth, $urandom_range(1, 20));
      else if (sel < 8) add_write(RegGridWidth, $urandom_range(21, MaxWidth));
      else if (sel < 9) add_write(RegGridWidth, $urandom_range(MaxWidth + 1, 511));
      else              add_write(RegGridWidth, 0);
      add_write(RegBoundaryMode, $urandom_range(0, 511));
      if ($urandom_range(0, 3) == 0) add_write(RegUnmapped, $urandom_range(0, 511));
      span = (Dims == 1) ? plan_w : plan_w * plan_w;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          cell_val = $urandom_range(0, span - 1);
        end else if (sel < 85) begin
          col      = edge_coord(plan_w);
          row      = edge_coord(plan_w);
          cell_val = (Dims == 1) ? col : row * plan_w + col;
        end else if (sel < 93) begin
          // Just past the last cell of the grid.
          extra    = span + $urandom_range(0, 3);
          cell_val = (extra > 16'hFFFF) ? $urandom_range(0, 16'hFFFF) : extra;
        end else begin
          cell_val = $urandom_range(0, 16'hFFFF);
        end
        add_cell(cell_val);
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || driver_active || expected_entries.size() != 0)
      @(posedge clk_i);
    // Any stray strobe after the last expected entry is caught meanwhile.
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
